// File: hw/rtl/lwbcd_pkg.sv
// ----------------------------------------------------------------------------
// lwbcd_pkg
// Shared types and constants of the LRU write-back cache directory.
// ----------------------------------------------------------------------------
package lwbcd_pkg;

  // Field widths fixed by the item layout, reset limit and default depth.
  localparam int TAG_W       = 32;
  localparam int SLOT_W      = 6;
  localparam int CMD_W       = 3;
  localparam int LIMIT_W     = 7;
  localparam int LIMIT_RESET = 24;
  localparam int DEF_ENTRIES = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PROBE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INVAL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INV_ALL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd6;

  // One directory entry as it sits in a cell of the LRU chain.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic              dirty;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  // Operation applied to the whole chain.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_MRU     = 3'd1,
    OP_ROT     = 3'd2,
    OP_CLR     = 3'd3,
    OP_INV_ALL = 3'd4
  } op_t;

  // Control broadcast to every cell.
  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] target;
  } chain_ctl_t;

endpackage

// File: hw/rtl/lru_writeback_block_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_directory
// Fully associative write-back cache directory with LRU replacement.
// ----------------------------------------------------------------------------
// Commands enter on s_axis: tuser carries the command code, tdata the block,
// the destination block and the read-first flag. Each command gives zero or
// more write-back items (tuser 0) in ascending block order on m_axis, then
// one completion item (tuser 1) with tlast high.
// The entries sit in a row of cells ordered from least to most recently used.
// A lookup compares all cells at once; an MRU move or a one-step rotation
// shifts the row by one position.
// A hit or a simple command is answered from S_LOOK; a clean miss passes
// through S_ALLOC and S_FILL, a move through S_MOV2 and S_MOV3. Each
// rotation step past a leading dirty entry is taken in S_ALLOC. A write-back
// sweep scans the row one cell a cycle in S_SCAN, each written-back block
// leaves from S_WBOUT, and a final empty sweep ends the series.
// One command is processed at a time; a new item is taken once the previous
// completion sits in the output register.
// Reset (rst, synchronous) empties the directory, sets slot i at position i
// and loads dirty_limit with 24. A stalled receiver holds the output item and
// stalls the sequencer at its next output until that item is taken.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache_directory #(
  parameter int ENTRIES = lwbcd_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  // Config: dirty_limit.
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // block[31:0], to_block[63:32], read_first[64], zero fill.
  input  logic [71:0] s_axis_tdata,
  // cmd[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_block[31:0], slot[37:32], hit[38], fetch[39], status[40], zero fill.
  output logic [47:0] m_axis_tdata,
  // kind[0].
  output logic        m_axis_tuser,
  // last.
  output logic        m_axis_tlast
);

  localparam int TW = lwbcd_pkg::TAG_W;
  localparam int SW = lwbcd_pkg::SLOT_W;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOOK  = 9'b000000010,
    S_ALLOC = 9'b000000100,
    S_FILL  = 9'b000001000,
    S_MOV2  = 9'b000010000,
    S_MOV3  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_WBOUT = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t                   state, state_next;
  logic [lwbcd_pkg::CMD_W-1:0] cmd;
  logic [TW-1:0]            blk, to_blk;
  logic                     rf;
  logic [SW-1:0]            s_slot, s_slot_next;
  logic                     hit_r, hit_r_next, fetch_r, fetch_r_next;
  logic [IW-1:0]            idx, idx_next;
  logic                     best_v, best_v_next;
  logic [TW-1:0]            best_tag, best_tag_next;
  logic [SW-1:0]            best_slot, best_slot_next;
  logic [CW-1:0]            cnt, cnt_next;
  logic [lwbcd_pkg::LIMIT_W-1:0] limit;

  lwbcd_pkg::chain_ctl_t    ctl;
  lwbcd_pkg::entry_t        ins;
  lwbcd_pkg::entry_t        ents [ENTRIES];
  logic [ENTRIES:0]         seen;
  logic [ENTRIES-1:0]       sel, hit_b, hit_t;

  lwbcd_pkg::entry_t        sel_e;
  logic                     found;
  logic [SW-1:0]            f_slot;
  logic                     t_found;
  logic [SW-1:0]            t_slot;
  lwbcd_pkg::entry_t        scan_e;
  logic                     rsv;
  logic                     out_free;

  logic                     emit;
  logic                     e_kind, e_hit, e_fetch, e_status, e_last;
  logic [TW-1:0]            e_block;
  logic [SW-1:0]            e_slot;

  // Row of cells, least recently used first.
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lwbcd_pkg::entry_t nb;
    if (i == ENTRIES - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_body
      assign nb = ents[i+1];
    end
    lwbcd_cell #(
      .INDEX   (i),
      .IS_LAST (i == ENTRIES - 1)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .nb       (nb),
      .ins      (ins),
      .blk      (blk),
      .to_blk   (to_blk),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .sel      (sel[i]),
      .hit_blk  (hit_b[i]),
      .hit_to   (hit_t[i]),
      .ent      (ents[i])
    );
  end

  // Merge the one-hot match lines of the row.
  always_comb begin
    sel_e   = '0;
    found   = 1'b0;
    f_slot  = '0;
    t_found = 1'b0;
    t_slot  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) sel_e = sel_e | ents[i];
      if (hit_b[i]) begin
        found  = 1'b1;
        f_slot = f_slot | ents[i].slot;
      end
      if (hit_t[i] && (ents[i].slot != s_slot)) begin
        t_found = 1'b1;
        t_slot  = t_slot | ents[i].slot;
      end
    end
  end

  assign scan_e        = ents[idx];
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign rsv = ((cmd inside {lwbcd_pkg::CMD_READ, lwbcd_pkg::CMD_PROBE,
                             lwbcd_pkg::CMD_WRITE, lwbcd_pkg::CMD_INVAL})
                && (blk == '0))
               || ((cmd == lwbcd_pkg::CMD_MOVE) && ((blk == '0) || (to_blk == '0)));

  // Command sequencer.
  always_comb begin
    state_next     = state;
    s_slot_next    = s_slot;
    hit_r_next     = hit_r;
    fetch_r_next   = fetch_r;
    idx_next       = idx;
    best_v_next    = best_v;
    best_tag_next  = best_tag;
    best_slot_next = best_slot;
    cnt_next       = cnt;
    ctl.op         = lwbcd_pkg::OP_NONE;
    ctl.target     = '0;
    ins            = '0;
    emit           = 1'b0;
    e_kind         = 1'b1;
    e_block        = '0;
    e_slot         = '0;
    e_hit          = 1'b0;
    e_fetch        = 1'b0;
    e_status       = 1'b0;
    e_last         = 1'b1;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_LOOK;
      end
      S_LOOK: begin
        ctl.target = f_slot;
        if (rsv) begin
          if (out_free) begin
            emit       = 1'b1;
            e_status   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          case (cmd)
            lwbcd_pkg::CMD_READ, lwbcd_pkg::CMD_WRITE: begin
              if (!found) begin
                state_next = S_ALLOC;
              end else if (out_free) begin
                ctl.op = lwbcd_pkg::OP_MRU;
                ins    = sel_e;
                if (cmd == lwbcd_pkg::CMD_WRITE) begin
                  ins.dirty = 1'b1;
                  if (!sel_e.dirty) cnt_next = cnt + CW'(1);
                end
                emit       = 1'b1;
                e_block    = blk;
                e_slot     = f_slot;
                e_hit      = 1'b1;
                state_next = S_IDLE;
              end
            end
            lwbcd_pkg::CMD_PROBE: begin
              if (out_free) begin
                if (found) begin
                  ctl.op  = lwbcd_pkg::OP_MRU;
                  ins     = sel_e;
                  e_block = blk;
                  e_slot  = f_slot;
                  e_hit   = 1'b1;
                end
                emit       = 1'b1;
                state_next = S_IDLE;
              end
            end
            lwbcd_pkg::CMD_INVAL: begin
              if (out_free) begin
                if (found) begin
                  ctl.op   = lwbcd_pkg::OP_MRU;
                  ins      = '0;
                  ins.slot = f_slot;
                  if (sel_e.dirty && (cnt != '0)) cnt_next = cnt - CW'(1);
                  e_slot = f_slot;
                  e_hit  = 1'b1;
                end
                emit       = 1'b1;
                state_next = S_IDLE;
              end
            end
            lwbcd_pkg::CMD_INV_ALL: begin
              if (out_free) begin
                ctl.op     = lwbcd_pkg::OP_INV_ALL;
                cnt_next   = '0;
                emit       = 1'b1;
                state_next = S_IDLE;
              end
            end
            lwbcd_pkg::CMD_MOVE: begin
              if (found) begin
                s_slot_next  = f_slot;
                hit_r_next   = 1'b1;
                fetch_r_next = 1'b0;
                state_next   = S_MOV2;
              end else begin
                state_next = S_ALLOC;
              end
            end
            lwbcd_pkg::CMD_FLUSH: begin
              idx_next    = '0;
              best_v_next = 1'b0;
              state_next  = S_SCAN;
            end
            default: begin
              if (out_free) begin
                emit       = 1'b1;
                state_next = S_IDLE;
              end
            end
          endcase
        end
      end
      S_ALLOC: begin
        // Victim: the row head; dirty ones are rotated past or written back.
        if (ents[0].dirty) begin
          if ((lwbcd_pkg::LIMIT_W'(cnt) > limit) || (cnt == CW'(ENTRIES))) begin
            idx_next    = '0;
            best_v_next = 1'b0;
            state_next  = S_SCAN;
          end else begin
            ctl.op = lwbcd_pkg::OP_ROT;
            ins    = ents[0];
          end
        end else begin
          s_slot_next  = ents[0].slot;
          hit_r_next   = 1'b0;
          fetch_r_next = (cmd == lwbcd_pkg::CMD_WRITE) ? rf : 1'b1;
          state_next   = (cmd == lwbcd_pkg::CMD_MOVE) ? S_MOV2 : S_FILL;
        end
      end
      S_FILL: begin
        ctl.target = s_slot;
        if (out_free) begin
          ctl.op    = lwbcd_pkg::OP_MRU;
          ins.tag   = blk;
          ins.valid = 1'b1;
          ins.dirty = (cmd == lwbcd_pkg::CMD_WRITE);
          ins.slot  = s_slot;
          if (cmd == lwbcd_pkg::CMD_WRITE) cnt_next = cnt + CW'(1);
          emit       = 1'b1;
          e_block    = blk;
          e_slot     = s_slot;
          e_fetch    = fetch_r;
          state_next = S_IDLE;
        end
      end
      S_MOV2: begin
        // Drop a stale copy of the destination block held in another slot.
        ctl.target = t_slot;
        if (t_found) begin
          ctl.op   = lwbcd_pkg::OP_MRU;
          ins      = '0;
          ins.slot = t_slot;
          if (sel_e.dirty && (cnt != '0)) cnt_next = cnt - CW'(1);
        end
        state_next = S_MOV3;
      end
      S_MOV3: begin
        ctl.target = s_slot;
        if (out_free) begin
          ctl.op    = lwbcd_pkg::OP_MRU;
          ins.tag   = to_blk;
          ins.valid = 1'b1;
          ins.dirty = 1'b1;
          ins.slot  = s_slot;
          if (!sel_e.dirty) cnt_next = cnt + CW'(1);
          emit       = 1'b1;
          e_block    = to_blk;
          e_slot     = s_slot;
          e_hit      = hit_r;
          e_fetch    = fetch_r;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // Search for the lowest dirty block, one cell a cycle.
        if (scan_e.dirty && (!best_v || (scan_e.tag < best_tag))) begin
          best_v_next    = 1'b1;
          best_tag_next  = scan_e.tag;
          best_slot_next = scan_e.slot;
        end
        if (idx == IW'(ENTRIES - 1)) begin
          state_next = S_WBOUT;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_WBOUT: begin
        ctl.target = best_slot;
        if (!best_v) begin
          cnt_next   = '0;
          state_next = (cmd == lwbcd_pkg::CMD_FLUSH) ? S_FIN : S_ALLOC;
        end else if (out_free) begin
          ctl.op      = lwbcd_pkg::OP_CLR;
          emit        = 1'b1;
          e_kind      = 1'b0;
          e_last      = 1'b0;
          e_block     = best_tag;
          e_slot      = best_slot;
          idx_next    = '0;
          best_v_next = 1'b0;
          state_next  = S_SCAN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      limit  <= lwbcd_pkg::LIMIT_W'(lwbcd_pkg::LIMIT_RESET);
      best_v <= 1'b0;
      idx    <= '0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      best_v <= best_v_next;
      idx    <= idx_next;
      if (cfg_we) limit <= cfg_wdata;
    end
  end

  // Command and search payload.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd    <= s_axis_tuser;
      blk    <= s_axis_tdata[31:0];
      to_blk <= s_axis_tdata[63:32];
      rf     <= s_axis_tdata[64];
    end
    s_slot    <= s_slot_next;
    hit_r     <= hit_r_next;
    fetch_r   <= fetch_r_next;
    best_tag  <= best_tag_next;
    best_slot <= best_slot_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {7'd0, e_status, e_fetch, e_hit, e_slot, e_block};
      m_axis_tuser <= e_kind;
      m_axis_tlast <= e_last;
    end
  end

  // The dirty count never exceeds the number of entries.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(ENTRIES))
    else $error("dirty count out of range");

  // An accepted command is looked up in the next cycle.
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == S_LOOK))
    else $error("accepted command not looked up");

  // A write-back item is never the final item of a command.
  a_wb_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> !m_axis_tlast)
    else $error("write-back item marked last");

  // The sequencer is idle after a completion is loaded.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && e_last) |=> (state == S_IDLE))
    else $error("completion without return to idle");

endmodule

// File: hw/rtl/lwbcd_cell.sv
// ----------------------------------------------------------------------------
// lwbcd_cell
// One position of the LRU chain: holds an entry, compares its tag and
// takes the entry of its neighbor on a shift.
// ----------------------------------------------------------------------------
module lwbcd_cell #(
  parameter int INDEX   = 0,
  parameter bit IS_LAST = 1'b0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lwbcd_pkg::chain_ctl_t        ctl,
  input  lwbcd_pkg::entry_t            nb,
  input  lwbcd_pkg::entry_t            ins,
  input  logic [lwbcd_pkg::TAG_W-1:0]  blk,
  input  logic [lwbcd_pkg::TAG_W-1:0]  to_blk,
  input  logic                         seen_in,
  output logic                         seen_out,
  output logic                         sel,
  output logic                         hit_blk,
  output logic                         hit_to,
  output lwbcd_pkg::entry_t            ent
);

  lwbcd_pkg::entry_t src;

  // The tail cell takes the inserted entry, every other cell its neighbor.
  assign src      = IS_LAST ? ins : nb;
  assign sel      = (ent.slot == ctl.target);
  assign seen_out = seen_in | sel;
  assign hit_blk  = ent.valid && (ent.tag == blk);
  assign hit_to   = ent.valid && (ent.tag == to_blk);

  // Entry update for the chain operation of this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.tag   <= '0;
      ent.valid <= 1'b0;
      ent.dirty <= 1'b0;
      ent.slot  <= lwbcd_pkg::SLOT_W'(INDEX);
    end else begin
      case (ctl.op)
        lwbcd_pkg::OP_MRU: begin
          if (seen_out) ent <= src;
        end
        lwbcd_pkg::OP_ROT: begin
          ent <= src;
        end
        lwbcd_pkg::OP_CLR: begin
          if (sel) ent.dirty <= 1'b0;
        end
        lwbcd_pkg::OP_INV_ALL: begin
          ent.tag   <= '0;
          ent.valid <= 1'b0;
          ent.dirty <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
